// File: rtl/ssr_pkg.sv
// ---------------------------------------------------------------------------
// ssr_pkg
// Shared types and constants of the stream search and replace unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssr_pkg;

    // one text byte
    typedef logic [7:0] t_byte;

    // configuration register index, wide enough to carry unused indexes
    typedef logic [7:0] t_cfg_idx;

    // configuration write data
    typedef logic [63:0] t_cfg_data;

    // length register width
    localparam int LEN_W = 4;
    typedef logic [LEN_W-1:0] t_len;

    // register indexes
    localparam t_cfg_idx CFG_PATTERN_BYTES      = 8'd0;
    localparam t_cfg_idx CFG_PATTERN_LENGTH     = 8'd1;
    localparam t_cfg_idx CFG_REPLACEMENT_BYTES  = 8'd2;
    localparam t_cfg_idx CFG_REPLACEMENT_LENGTH = 8'd3;

    // byte carried by the line break result
    localparam t_byte NEWLINE_BYTE = 8'h0A;

endpackage

`default_nettype wire

// File: rtl/ssr_in_if.sv
// ---------------------------------------------------------------------------
// ssr_in_if
// Input item channel: one text byte or a line end marker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ssr_in_if;
    logic          valid;
    logic          ready;
    ssr_pkg::t_byte data_byte;
    logic          line_end;

    modport source (output valid, data_byte, line_end, input ready);
    modport sink   (input valid, data_byte, line_end, output ready);
endinterface

`default_nettype wire

// File: rtl/ssr_out_if.sv
// ---------------------------------------------------------------------------
// ssr_out_if
// Result item channel: output byte, line break flag, end of run flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ssr_out_if;
    logic          valid;
    logic          ready;
    ssr_pkg::t_byte out_byte;
    logic          newline_mark;
    logic          last_of_run;

    modport source (output valid, out_byte, newline_mark, last_of_run, input ready);
    modport sink   (input valid, out_byte, newline_mark, last_of_run, output ready);
endinterface

`default_nettype wire

// File: rtl/ssr_cfg_if.sv
// ---------------------------------------------------------------------------
// ssr_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ssr_cfg_if;
    logic               valid;
    logic               ready;
    ssr_pkg::t_cfg_idx  index;
    ssr_pkg::t_cfg_data data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/stream_search_replace_unit.sv
// ---------------------------------------------------------------------------
// stream_search_replace_unit
// Streaming find and replace over a line structured byte stream.
// ---------------------------------------------------------------------------
//
//  channel  | dir | payload                                   | handshake
//  ---------+-----+-------------------------------------------+------------
//  i_in     | in  | data_byte[7:0], line_end                  | valid/ready
//  o_out    | out | out_byte[7:0], newline_mark, last_of_run  | valid/ready
//  i_cfg    | in  | index[7:0], data[63:0]                    | valid/ready
//
//  One item is accepted per cycle while its results fit: the pending window
//  is matched against all shift positions in the accept cycle, and the
//  results (up to max(MAX_PATTERN, MAX_REPLACEMENT)) go to a result list.
//  The list drains one result per cycle into the output register while the
//  output is not stalled. Synchronous active low reset clears the window
//  count, the result list count and head, the output valid flag and the
//  configuration registers to their reset values. The configuration port is
//  always ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stream_search_replace_unit #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ssr_in_if.sink      i_in,
    ssr_out_if.source   o_out,
    ssr_cfg_if.sink     i_cfg
);

    // window count holds 0..MAX_PATTERN, window index 0..MAX_PATTERN-1
    localparam int CW  = $clog2(MAX_PATTERN + 1);
    localparam int PIW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    // result list depth and its count and index widths
    localparam int LD  = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
    localparam int LCW = $clog2(LD + 1);
    localparam int LIW = (LD > 1) ? $clog2(LD) : 1;

    // configuration registers
    ssr_pkg::t_cfg_data r_pat, r_rep;
    ssr_pkg::t_len      r_plen, r_rlen;

    // pending window
    ssr_pkg::t_byte     r_win [MAX_PATTERN];
    ssr_pkg::t_byte     n_win [MAX_PATTERN];
    logic [CW-1:0]      r_pcnt, n_pcnt;

    // result list
    ssr_pkg::t_byte     r_lbyte [LD];
    logic               r_lnl   [LD];
    ssr_pkg::t_byte     n_lbyte [LD];
    logic               n_lnl   [LD];
    logic [LCW-1:0]     r_rem, n_rem;
    logic [LIW-1:0]     r_head;

    // output register
    logic               r_out_valid;
    ssr_pkg::t_byte     r_out_byte;
    logic               r_out_nl;
    logic               r_out_last;

    // match datapath
    ssr_pkg::t_byte     ext [MAX_PATTERN];
    logic               ok  [MAX_PATTERN+1];
    logic [CW-1:0]      n1;
    logic [CW-1:0]      sel;
    ssr_pkg::t_len      plen_eff, rlen_eff;
    logic               match;

    // handshake
    logic               out_free;
    logic               pop;
    logic               in_acc;
    logic               cfg_acc;
    logic               cfg_pat_wr;

    assign out_free = !r_out_valid || o_out.ready;
    assign pop      = out_free && (r_rem != '0);
    assign i_in.ready = (r_rem == '0) || ((r_rem == LCW'(1)) && out_free);
    assign in_acc   = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign cfg_acc  = i_cfg.valid;
    assign cfg_pat_wr = cfg_acc && ((i_cfg.index == ssr_pkg::CFG_PATTERN_BYTES) ||
                                    (i_cfg.index == ssr_pkg::CFG_PATTERN_LENGTH));

    assign o_out.valid        = r_out_valid;
    assign o_out.out_byte     = r_out_byte;
    assign o_out.newline_mark = r_out_nl;
    assign o_out.last_of_run  = r_out_last;

    // effective lengths
    always_comb begin
        if (r_plen == '0) begin
            plen_eff = ssr_pkg::LEN_W'(1);
        end else if (r_plen > ssr_pkg::LEN_W'(MAX_PATTERN)) begin
            plen_eff = ssr_pkg::LEN_W'(MAX_PATTERN);
        end else begin
            plen_eff = r_plen;
        end
        if (r_rlen > ssr_pkg::LEN_W'(MAX_REPLACEMENT)) begin
            rlen_eff = ssr_pkg::LEN_W'(MAX_REPLACEMENT);
        end else begin
            rlen_eff = r_rlen;
        end
    end

    // window with the new byte appended, checked at every shift
    always_comb begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
            ext[j] = r_win[j];
        end
        ext[r_pcnt[PIW-1:0]] = i_in.data_byte;
        n1 = r_pcnt + CW'(1);
        for (int s = 0; s <= MAX_PATTERN; s++) begin
            ok[s] = 1'b1;
            for (int j = 0; j < MAX_PATTERN; j++) begin
                if (j >= s) begin
                    if ((CW'(j) < n1) && (ext[j] != r_pat[8*(j-s) +: 8])) begin
                        ok[s] = 1'b0;
                    end
                end
            end
        end
        // leftmost shift that still leaves a pattern prefix
        sel = CW'(MAX_PATTERN);
        for (int s = MAX_PATTERN; s >= 0; s--) begin
            if (ok[s]) begin
                sel = CW'(s);
            end
        end
        match = (sel == '0) && (ssr_pkg::LEN_W'(n1) == plen_eff);
    end

    // results and next window for the accepted item
    always_comb begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
            n_win[j] = ext[j];
        end
        for (int k = 0; k < LD; k++) begin
            n_lbyte[k] = ssr_pkg::NEWLINE_BYTE;
            n_lnl[k]   = 1'b0;
        end
        n_rem  = '0;
        n_pcnt = '0;
        if (i_in.line_end) begin
            // flush held bytes, then the line break
            for (int j = 0; j < MAX_PATTERN; j++) begin
                n_win[j] = r_win[j];
            end
            for (int k = 0; k < LD; k++) begin
                if (k < MAX_PATTERN) begin
                    if (CW'(k) < r_pcnt) begin
                        n_lbyte[k] = r_win[k];
                    end
                    n_lnl[k] = (CW'(k) == r_pcnt);
                end
            end
            n_rem = LCW'(n1);
        end else if (match) begin
            for (int k = 0; k < LD; k++) begin
                n_lbyte[k] = r_rep[8*k +: 8];
            end
            n_rem = LCW'(rlen_eff);
        end else begin
            // bytes that can no longer start a match leave the window
            for (int k = 0; k < LD; k++) begin
                if (k < MAX_PATTERN) begin
                    n_lbyte[k] = ext[k];
                end
            end
            n_rem = LCW'(sel);
            for (int j = 0; j < MAX_PATTERN; j++) begin
                for (int t = 0; t <= MAX_PATTERN; t++) begin
                    if ((j + t < MAX_PATTERN) && (CW'(t) == sel)) begin
                        n_win[j] = ext[j + t];
                    end
                end
            end
            n_pcnt = n1 - sel;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat       <= '0;
            r_plen      <= ssr_pkg::LEN_W'(1);
            r_rep       <= '0;
            r_rlen      <= '0;
            r_pcnt      <= '0;
            r_rem       <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= (r_rem != '0);
            end
            // new item replaces the drained list, else the list drains
            if (in_acc) begin
                r_rem  <= n_rem;
                r_head <= '0;
            end else if (pop) begin
                r_rem  <= r_rem - LCW'(1);
                r_head <= r_head + LIW'(1);
            end
            // a pattern bytes or pattern length write drops the held bytes
            if (cfg_pat_wr) begin
                r_pcnt <= '0;
            end else if (in_acc) begin
                r_pcnt <= n_pcnt;
            end
            // configuration writes
            if (cfg_acc) begin
                unique case (i_cfg.index)
                    ssr_pkg::CFG_PATTERN_BYTES: begin
                        r_pat <= i_cfg.data;
                    end
                    ssr_pkg::CFG_PATTERN_LENGTH: begin
                        r_plen <= i_cfg.data[ssr_pkg::LEN_W-1:0];
                    end
                    ssr_pkg::CFG_REPLACEMENT_BYTES: begin
                        r_rep <= i_cfg.data;
                    end
                    ssr_pkg::CFG_REPLACEMENT_LENGTH: begin
                        r_rlen <= i_cfg.data[ssr_pkg::LEN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out_byte <= r_lbyte[r_head];
            r_out_nl   <= r_lnl[r_head];
            r_out_last <= (r_rem == LCW'(1));
        end
        if (in_acc) begin
            for (int j = 0; j < MAX_PATTERN; j++) begin
                r_win[j] <= n_win[j];
            end
            for (int k = 0; k < LD; k++) begin
                r_lbyte[k] <= n_lbyte[k];
                r_lnl[k]   <= n_lnl[k];
            end
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/ssr_result_checker.sv
// ---------------------------------------------------------------------------
// ssr_result_checker
// Watches the item, result and configuration channels of the stream search
// and replace unit, predicts the result items of every accepted item and
// compares each accepted result field by field with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssr_result_checker (
    input  wire  i_clk,
    input  wire  i_rst_n,
    ssr_in_if    in_ch,
    ssr_out_if   out_ch,
    ssr_cfg_if   cfg_ch,
    output int   o_fail_count,
    output int   o_pending_count
);

    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int MAX_PRINTED     = 100;

    typedef struct packed {
        ssr_pkg::t_byte out_byte;
        logic           newline_mark;
        logic           last_of_run;
    } t_result;

    // configuration copy
    ssr_pkg::t_cfg_data pat_word;
    ssr_pkg::t_len      pat_len_reg;
    ssr_pkg::t_cfg_data rep_word;
    ssr_pkg::t_len      rep_len_reg;

    // bytes that could still begin a match
    ssr_pkg::t_byte     held_bytes [0:MAX_PATTERN-1];
    int                 held_count;

    t_result            expected_results [$];

    function automatic t_result make_result(input ssr_pkg::t_byte b, input logic nl);
        t_result r;
        r.out_byte     = b;
        r.newline_mark = nl;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        o_fail_count++;
        if (o_fail_count <= MAX_PRINTED) begin
            $display("%0t mismatch: %s expected %0h got %0h", $realtime, what, exp_v, got_v);
        end
    endtask

    // work out the results of one item and queue them
    task automatic predict_item(input ssr_pkg::t_byte b, input logic le);
        t_result run_buf [0:15];
        int      k;
        int      plen;
        int      rlen;
        int      i;
        bit      is_prefix;
        bit      done;
        k    = 0;
        done = 0;
        plen = pat_len_reg;
        if (plen == 0) plen = 1;
        if (plen > MAX_PATTERN) plen = MAX_PATTERN;
        if (le) begin
            // flush held bytes unchanged, then the line break
            for (i = 0; i < held_count; i++) begin
                run_buf[k] = make_result(held_bytes[i], 1'b0);
                k++;
            end
            held_count = 0;
            run_buf[k] = make_result(ssr_pkg::NEWLINE_BYTE, 1'b1);
            k++;
        end else begin
            held_bytes[held_count] = b;
            held_count++;
            while (held_count > 0 && !done) begin
                is_prefix = 1;
                for (i = 0; i < held_count; i++) begin
                    if (held_bytes[i] != pat_word[8*i +: 8]) is_prefix = 0;
                end
                if (is_prefix) begin
                    // full match: replacement goes out, window empties
                    if (held_count >= plen) begin
                        rlen = (rep_len_reg > MAX_REPLACEMENT) ? MAX_REPLACEMENT : rep_len_reg;
                        for (i = 0; i < rlen; i++) begin
                            run_buf[k] = make_result(rep_word[8*i +: 8], 1'b0);
                            k++;
                        end
                        held_count = 0;
                    end
                    done = 1;
                end else begin
                    // oldest byte can no longer start a match
                    run_buf[k] = make_result(held_bytes[0], 1'b0);
                    k++;
                    for (i = 1; i < held_count; i++) held_bytes[i-1] = held_bytes[i];
                    held_count--;
                end
            end
        end
        if (k > 0) run_buf[k-1].last_of_run = 1'b1;
        for (i = 0; i < k; i++) expected_results.push_back(run_buf[i]);
    endtask

    // channel monitor
    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            pat_word    = '0;
            pat_len_reg = 4'd1;
            rep_word    = '0;
            rep_len_reg = 4'd0;
            held_count  = 0;
            expected_results.delete();
            o_fail_count = 0;
        end else begin
            // register write
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    ssr_pkg::CFG_PATTERN_BYTES: begin
                        pat_word   = cfg_ch.data;
                        held_count = 0;
                    end
                    ssr_pkg::CFG_PATTERN_LENGTH: begin
                        pat_len_reg = cfg_ch.data[ssr_pkg::LEN_W-1:0];
                        held_count  = 0;
                    end
                    ssr_pkg::CFG_REPLACEMENT_BYTES: begin
                        rep_word = cfg_ch.data;
                    end
                    ssr_pkg::CFG_REPLACEMENT_LENGTH: begin
                        rep_len_reg = cfg_ch.data[ssr_pkg::LEN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            // accepted input item
            if (in_ch.valid && in_ch.ready) begin
                predict_item(in_ch.data_byte, in_ch.line_end);
            end
            // accepted result item
            if (out_ch.valid && out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, out_byte", 0, out_ch.out_byte);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (out_ch.out_byte !== exp_r.out_byte) begin
                        report_mismatch("out_byte", exp_r.out_byte, out_ch.out_byte);
                    end
                    if (out_ch.newline_mark !== exp_r.newline_mark) begin
                        report_mismatch("newline_mark", exp_r.newline_mark, out_ch.newline_mark);
                    end
                    if (out_ch.last_of_run !== exp_r.last_of_run) begin
                        report_mismatch("last_of_run", exp_r.last_of_run, out_ch.last_of_run);
                    end
                end
            end
        end
        o_pending_count = expected_results.size();
    end

endmodule

// File: tb/sv/tb_stream_search_replace_unit.sv
// ---------------------------------------------------------------------------
// tb_stream_search_replace_unit
// Drives the stream search and replace unit with directed lines covering
// length saturation, empty replacement, mid-line pattern rewrite and unused
// register indexes, then with random lines built from pattern copies,
// partial prefixes and noise under several settings, with bursty input and
// a stalling receiver. A separate checker predicts and compares results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_stream_search_replace_unit;

    localparam ssr_pkg::t_cfg_idx CFG_UNUSED_LOW  = 8'd4;
    localparam ssr_pkg::t_cfg_idx CFG_UNUSED_HIGH = 8'hFF;
    localparam int                RANDOM_ITEMS    = 100;
    localparam int                SETTLE_CYCLES   = 8;
    localparam int                MAX_PATTERN     = 8;

    typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_SPARSE, RX_BURSTY} t_rx_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ssr_in_if  in_ch ();
    ssr_out_if out_ch ();
    ssr_cfg_if cfg_ch ();

    int fail_count;
    int pending_count;

    // stimulus state
    ssr_pkg::t_cfg_data cur_pattern;
    int                 cur_plen;
    ssr_pkg::t_byte     alpha [0:2];
    int                 burst_left;
    int                 items_sent;

    // receiver state
    t_rx_mode   rx_mode    = RX_FREE;
    int         mode_left  = 32;
    int         stall_left = 0;
    logic [1:0] sparse_cnt = '0;

    stream_search_replace_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    ssr_result_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .cfg_ch          (cfg_ch),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    always #5 i_clk = ~i_clk;

    // run limit
    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            rx_mode   <= t_rx_mode'($urandom_range(0, 3));
            mode_left <= $urandom_range(16, 64);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (rx_mode)
            RX_FREE: begin
                out_ch.ready <= 1'b1;
            end
            RX_RANDOM: begin
                out_ch.ready <= $urandom_range(0, 1);
            end
            RX_SPARSE: begin
                sparse_cnt   <= sparse_cnt + 2'd1;
                out_ch.ready <= (sparse_cnt == 2'd0);
            end
            default: begin
                if (stall_left != 0) begin
                    out_ch.ready <= 1'b0;
                    stall_left   <= stall_left - 1;
                end else begin
                    out_ch.ready <= 1'b1;
                    if ($urandom_range(0, 5) == 0) stall_left <= $urandom_range(4, 12);
                end
            end
        endcase
    end

    // one item, sent in bursts with random gaps
    task automatic send_item(input ssr_pkg::t_byte b, input logic le);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.line_end  <= le;
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;
        items_sent++;
    endtask

    // hold off until every expected result has come and the block is quiet
    task automatic settle_idle();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input ssr_pkg::t_cfg_idx idx, input ssr_pkg::t_cfg_data val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input ssr_pkg::t_cfg_data pat, input ssr_pkg::t_len plen_v,
                                 input ssr_pkg::t_cfg_data rep, input ssr_pkg::t_len rlen_v);
        settle_idle();
        write_reg(ssr_pkg::CFG_PATTERN_BYTES, pat);
        write_reg(ssr_pkg::CFG_PATTERN_LENGTH, ssr_pkg::t_cfg_data'(plen_v));
        write_reg(ssr_pkg::CFG_REPLACEMENT_BYTES, rep);
        write_reg(ssr_pkg::CFG_REPLACEMENT_LENGTH, ssr_pkg::t_cfg_data'(rlen_v));
        cur_pattern = pat;
        cur_plen    = (plen_v == 0) ? 1 : ((plen_v > MAX_PATTERN) ? MAX_PATTERN : plen_v);
    endtask

    // a piece of a line: pattern copy, broken prefix, alphabet byte, noise or line end
    task automatic send_chunk();
        int kind;
        int n;
        int i;
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
            for (i = 0; i < cur_plen; i++) send_item(cur_pattern[8*i +: 8], 1'b0);
        end else if (kind < 6) begin
            n = $urandom_range(0, cur_plen - 1);
            for (i = 0; i < n; i++) send_item(cur_pattern[8*i +: 8], 1'b0);
            send_item(alpha[$urandom_range(0, 2)], 1'b0);
        end else if (kind < 8) begin
            send_item(alpha[$urandom_range(0, 2)], 1'b0);
        end else if (kind == 8) begin
            send_item(ssr_pkg::t_byte'($urandom), 1'b0);
        end else begin
            send_item(ssr_pkg::t_byte'($urandom), 1'b1);
        end
    endtask

    // stimulus
    initial begin
        int                 phase;
        int                 start;
        int                 phase_items;
        int                 i;
        bit                 paused;
        ssr_pkg::t_cfg_data pat;
        ssr_pkg::t_len      plen_v;
        ssr_pkg::t_len      rlen_v;

        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.line_end  = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = ssr_pkg::CFG_PATTERN_BYTES;
        cfg_ch.data     = '0;
        out_ch.ready    = 1'b1;
        burst_left      = 0;
        items_sent      = 0;
        paused          = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: one byte pattern 0x00, empty replacement
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b1);

        // two byte pattern, three byte replacement, partial then full match
        apply_setting(64'h6261, 4'd2, 64'h5A5958, 4'd3);
        send_item(8'h61, 1'b0);
        send_item(8'h62, 1'b0);
        send_item(8'h61, 1'b0);
        send_item(8'h61, 1'b0);
        send_item(8'h62, 1'b0);
        send_item(8'h61, 1'b0);
        send_item(8'h00, 1'b1);

        // pattern length zero acts as one
        apply_setting(64'h41, 4'd0, 64'h5A, 4'd1);
        send_item(8'h41, 1'b0);
        send_item(8'h42, 1'b0);

        // lengths above the maximum saturate; flush of a seven byte window at line end
        apply_setting(64'h8877665544332211, 4'hF, 64'hFFFFFFFFFFFFFFFF, 4'hF);
        for (i = 1; i < MAX_PATTERN; i++) send_item(ssr_pkg::t_byte'(8'h11 * i), 1'b0);
        send_item(8'hFF, 1'b1);

        // pattern length rewritten mid-line drops the held bytes; unused indexes ignored
        send_item(8'h11, 1'b0);
        send_item(8'h22, 1'b0);
        send_item(8'h33, 1'b0);
        settle_idle();
        write_reg(ssr_pkg::CFG_PATTERN_LENGTH, 64'd2);
        write_reg(CFG_UNUSED_LOW, 64'h0123456789ABCDEF);
        write_reg(CFG_UNUSED_HIGH, 64'hFFFFFFFFFFFFFFFF);
        cur_plen = 2;
        send_item(8'h5A, 1'b1);

        // random lines under changing settings
        phase = 0;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            for (i = 0; i < 3; i++) alpha[i] = ssr_pkg::t_byte'($urandom);
            pat = {$urandom, $urandom};
            for (i = 0; i < MAX_PATTERN; i++) begin
                if ($urandom_range(0, 4) != 0) pat[8*i +: 8] = alpha[$urandom_range(0, 2)];
            end
            if (phase % 4 == 0) begin
                plen_v = 4'd8;
                rlen_v = 4'd8;
            end else if (phase % 4 == 1) begin
                plen_v = 4'd1;
                rlen_v = 4'd0;
            end else begin
                plen_v = ssr_pkg::t_len'($urandom_range(0, 10));
                rlen_v = ssr_pkg::t_len'($urandom_range(0, 10));
            end
            apply_setting(pat, plen_v, {$urandom, $urandom}, rlen_v);
            phase_items = items_sent + $urandom_range(14, 22);
            while (items_sent < phase_items) begin
                send_chunk();
                // sender waits once during the third setting for the receiver to catch up
                if (phase == 2 && !paused && items_sent + 8 >= phase_items) begin
                    settle_idle();
                    paused = 1;
                end
            end
            phase++;
        end

        settle_idle();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/ssr_pkg.sv
rtl/ssr_in_if.sv
rtl/ssr_out_if.sv
rtl/ssr_cfg_if.sv
rtl/stream_search_replace_unit.sv
tb/sv/ssr_result_checker.sv
tb/sv/tb_stream_search_replace_unit.sv
